### hw/rtl/char_frame_shape_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// char_frame_shape_rasterizer_assert.svh
// Assertion macros for the character frame rasterizer. Compiled out under SYNTH.
// ----------------------------------------------------------------------------
`ifndef CHAR_FRAME_SHAPE_RASTERIZER_ASSERT_SVH
`define CHAR_FRAME_SHAPE_RASTERIZER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset
`define CFSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define CFSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CFSR_ASSERT_NOW(lbl, ante, cons, msg)
`define CFSR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hw/rtl/cfsr_pkg.sv
// ----------------------------------------------------------------------------
// cfsr_pkg
// Shared types and constants of the character frame shape rasterizer.
// ----------------------------------------------------------------------------
package cfsr_pkg;

    // Field and internal widths
    localparam int DIM_W  = 7;   // active sizes and scan counters
    localparam int CHAR_W = 8;   // one character cell
    localparam int R2_W   = 14;  // r*r and r*r +/- r
    localparam int SQ_W   = 16;  // one squared offset
    localparam int D_W    = 17;  // sum of two squared offsets

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Drawing commands
    typedef enum logic [2:0] {
        OP_RING  = 3'd0,
        OP_DISK  = 3'd1,
        OP_RECT  = 3'd2,
        OP_BOX   = 3'd3,
        OP_POINT = 3'd4,
        OP_CLEAR = 3'd5,
        OP_READ  = 3'd6
    } op_t;

    // Control states of the top level
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_RD_WAIT,
        ST_RD_DATA
    } state_t;

    // One accepted command
    typedef struct packed {
        op_t               op;
        logic signed [7:0] row_a;
        logic signed [7:0] col_a;
        logic signed [7:0] row_b;
        logic signed [7:0] col_b;
        logic [6:0]        radius;
        logic [CHAR_W-1:0] glyph;
    } req_t;

endpackage

### hw/rtl/cfsr_frame_mem.sv
// ----------------------------------------------------------------------------
// cfsr_frame_mem
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cfsr_frame_mem
    import cfsr_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CHAR_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CHAR_W-1:0] rd_data
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/cfsr_scan.sv
// ----------------------------------------------------------------------------
// cfsr_scan
// Canvas scanner: walks every active pixel, one a cycle, and decides in a
// two-stage pipe what each shape writes there.
// ----------------------------------------------------------------------------
module cfsr_scan
    import cfsr_pkg::*;
#(
    parameter int MAX_WIDTH = 64,
    parameter int ADDR_W    = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  req_t              req,
    input  logic [DIM_W-1:0]  eff_w,
    input  logic [DIM_W-1:0]  eff_h,
    output logic              busy,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [CHAR_W-1:0] wr_data
);

    // Command held for the whole scan
    req_t              req_reg;
    logic [R2_W-1:0]   r_sq_reg;
    logic [R2_W-1:0]   ring_lo_reg;
    logic [R2_W-1:0]   ring_hi_reg;

    // Pixel counters
    logic              run_reg;
    logic [DIM_W-1:0]  i_reg;
    logic [DIM_W-1:0]  j_reg;

    // Stage 1
    logic              p1_v_reg;
    logic [DIM_W-1:0]  p1_i_reg;
    logic [DIM_W-1:0]  p1_j_reg;

    // Stage 2
    logic              p2_v_reg;
    logic [ADDR_W-1:0] p2_addr_reg;
    logic [SQ_W-1:0]   p2_sqi_reg;
    logic [SQ_W-1:0]   p2_sqj_reg;
    logic              p2_rect_we_reg;

    logic [R2_W-1:0]   r_sq_c;
    logic signed [8:0] di;
    logic signed [8:0] dj;
    logic signed [8:0] i_s;
    logic signed [8:0] j_s;
    logic signed [8:0] rb_s;
    logic signed [8:0] cb_s;
    logic signed [17:0] di_sq;
    logic signed [17:0] dj_sq;
    logic              in_box;
    logic              on_border;
    logic              rect_we;
    logic [D_W-1:0]    dist_sq;
    logic              ring_hit;
    logic              disk_hit;

    // Radius thresholds, worked out once per command
    assign r_sq_c = {7'd0, req.radius} * {7'd0, req.radius};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg     <= req;
            r_sq_reg    <= r_sq_c;
            ring_lo_reg <= r_sq_c - {7'd0, req.radius};
            ring_hi_reg <= r_sq_c + {7'd0, req.radius};
        end
    end

    // Row-major pixel walk over the active canvas
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            i_reg   <= '0;
            j_reg   <= '0;
        end
        else if (start)
        begin
            run_reg <= (eff_w != '0) && (eff_h != '0);
            i_reg   <= '0;
            j_reg   <= '0;
        end
        else if (run_reg)
        begin
            if (j_reg == eff_w - 1'b1)
            begin
                j_reg <= '0;
                if (i_reg == eff_h - 1'b1)
                begin
                    run_reg <= 1'b0;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end
        else
        begin
            p1_v_reg <= run_reg;
            p2_v_reg <= p1_v_reg;
        end
    end

    // Stage 1: offsets, squares, rectangle membership
    always_comb
    begin
        i_s       = $signed({2'b00, p1_i_reg});
        j_s       = $signed({2'b00, p1_j_reg});
        rb_s      = $signed({req_reg.row_b[7], req_reg.row_b});
        cb_s      = $signed({req_reg.col_b[7], req_reg.col_b});
        di        = i_s - $signed({req_reg.row_a[7], req_reg.row_a});
        dj        = j_s - $signed({req_reg.col_a[7], req_reg.col_a});
        di_sq     = di * di;
        dj_sq     = dj * dj;
        in_box    = (di >= 0) && (i_s <= rb_s) && (dj >= 0) && (j_s <= cb_s);
        on_border = (di == 0) || (i_s == rb_s) || (dj == 0) || (j_s == cb_s);
        rect_we   = in_box && ((req_reg.op == OP_BOX) || on_border);
    end

    always_ff @(posedge clk)
    begin
        p1_i_reg       <= i_reg;
        p1_j_reg       <= j_reg;
        p2_addr_reg    <= ADDR_W'(p1_i_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(p1_j_reg);
        p2_sqi_reg     <= di_sq[SQ_W-1:0];
        p2_sqj_reg     <= dj_sq[SQ_W-1:0];
        p2_rect_we_reg <= rect_we;
    end

    // Stage 2: distance test and write decision
    always_comb
    begin
        dist_sq  = {1'b0, p2_sqi_reg} + {1'b0, p2_sqj_reg};
        ring_hit = (dist_sq >= D_W'(ring_lo_reg)) && (dist_sq <= D_W'(ring_hi_reg));
        disk_hit = dist_sq <= D_W'(r_sq_reg);
        wr_en    = 1'b0;
        wr_data  = SPACE_CHAR;
        case (req_reg.op)
            OP_RING:
            begin
                wr_en   = p2_v_reg;
                wr_data = ring_hit ? req_reg.glyph : SPACE_CHAR;
            end
            OP_DISK:
            begin
                wr_en   = p2_v_reg;
                wr_data = disk_hit ? req_reg.glyph : SPACE_CHAR;
            end
            OP_RECT, OP_BOX:
            begin
                wr_en   = p2_v_reg && p2_rect_we_reg;
                wr_data = req_reg.glyph;
            end
            OP_CLEAR:
            begin
                wr_en   = p2_v_reg;
                wr_data = SPACE_CHAR;
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_data = SPACE_CHAR;
            end
        endcase
    end

    assign wr_addr = p2_addr_reg;
    assign busy    = run_reg || p1_v_reg || p2_v_reg;

endmodule

### hw/rtl/char_frame_shape_rasterizer.sv
// Circle, rectangle and clear commands scan the active canvas, one pixel a cycle.
// Set point and command 7 complete in the idle state; a read passes a wait state and a
// data state before its result is loaded, and a held result stalls the next read.
// After reset a clearing pass writes spaces to all MAX_WIDTH * MAX_HEIGHT cells before
// the first command is taken; config writes are taken throughout.
// ----------------------------------------------------------------------------
// char_frame_shape_rasterizer
// Character frame store with a shape rasterizer: command decode, frame store
// arbitration, clearing pass, pixel read and result register.
// ----------------------------------------------------------------------------
`include "char_frame_shape_rasterizer_assert.svh"

module char_frame_shape_rasterizer
    import cfsr_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic              clk,
    input  logic              rst_n,

    // Command channel
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic [2:0]        command,
    input  logic signed [7:0] row_a,
    input  logic signed [7:0] col_a,
    input  logic signed [7:0] row_b,
    input  logic signed [7:0] col_b,
    input  logic [6:0]        radius,
    input  logic [7:0]        glyph,

    // Result channel
    output logic              result_valid,
    input  logic              result_stall,
    output logic [7:0]        pixel_value,

    // Configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t            state_reg;
    state_t            state_next;
    logic [DIM_W-1:0]  active_width_reg;
    logic [DIM_W-1:0]  active_height_reg;
    logic [ADDR_W-1:0] init_cnt_reg;
    logic [ADDR_W-1:0] init_cnt_next;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              rd_off_reg;
    logic              result_valid_reg;
    logic              result_valid_next;
    logic [CHAR_W-1:0] pixel_value_reg;
    logic              result_load;

    logic [DIM_W-1:0]  eff_w;
    logic [DIM_W-1:0]  eff_h;
    req_t              req;
    logic              accept;
    logic              on_canvas;
    logic [ADDR_W-1:0] pt_addr;
    logic              scan_start;
    logic              scan_busy;
    logic              scan_we;
    logic [ADDR_W-1:0] scan_addr;
    logic [CHAR_W-1:0] scan_data;
    logic              init_we;
    logic              pt_we;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic [CHAR_W-1:0] mem_rdata;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_width_reg  <= 7'd64;
            active_height_reg <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  active_width_reg  <= cfg_data;
                CFG_HEIGHT: active_height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Active sizes saturate at the store size
    assign eff_w = (32'(active_width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : active_width_reg;
    assign eff_h = (32'(active_height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT)
                                                         : active_height_reg;

    // Command decode
    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        req.op     = op_t'(command);
        req.row_a  = row_a;
        req.col_a  = col_a;
        req.row_b  = row_b;
        req.col_b  = col_b;
        req.radius = radius;
        req.glyph  = glyph;
    end

    assign on_canvas = !row_a[7] && (row_a < $signed({1'b0, eff_h}))
                    && !col_a[7] && (col_a < $signed({1'b0, eff_w}));
    assign pt_addr   = ADDR_W'(row_a[6:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_a[6:0]);

    assign scan_start = accept && ((req.op == OP_RING) || (req.op == OP_DISK)
                     || (req.op == OP_RECT) || (req.op == OP_BOX) || (req.op == OP_CLEAR));
    assign pt_we      = accept && (req.op == OP_POINT) && on_canvas;

    // Pixel scanner
    cfsr_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .req     (req),
        .eff_w   (eff_w),
        .eff_h   (eff_h),
        .busy    (scan_busy),
        .wr_en   (scan_we),
        .wr_addr (scan_addr),
        .wr_data (scan_data)
    );

    // Write port arbitration: clearing pass, scanner, set point
    assign init_we = (state_reg == ST_INIT);

    always_comb
    begin
        if (init_we)
        begin
            mem_we    = 1'b1;
            mem_waddr = init_cnt_reg;
            mem_wdata = SPACE_CHAR;
        end
        else if (scan_we)
        begin
            mem_we    = 1'b1;
            mem_waddr = scan_addr;
            mem_wdata = scan_data;
        end
        else
        begin
            mem_we    = pt_we;
            mem_waddr = pt_addr;
            mem_wdata = glyph;
        end
    end

    cfsr_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (rd_addr_reg),
        .rd_data (mem_rdata)
    );

    // Read address and off-canvas flag, captured on a read transfer
    always_ff @(posedge clk)
    begin
        if (accept && (req.op == OP_READ))
        begin
            rd_addr_reg <= pt_addr;
            rd_off_reg  <= !on_canvas;
        end
    end

    // Control state machine
    always_comb
    begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        result_load   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                init_cnt_next = init_cnt_reg + 1'b1;
                if (init_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (scan_start)
                begin
                    state_next = ST_SCAN;
                end
                else if (accept && (req.op == OP_READ))
                begin
                    state_next = ST_RD_WAIT;
                end
            end
            ST_SCAN:
            begin
                if (!scan_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                // read data stays valid while the result register is full
                if (!result_valid_reg || !result_stall)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
        end
    end

    // Result register
    assign result_valid_next = result_load || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            pixel_value_reg <= rd_off_reg ? SPACE_CHAR : mem_rdata;
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel_value  = pixel_value_reg;

    // Checks
    `CFSR_ASSERT_NOW(a_accept_scan_idle, accept, !scan_busy, "command taken while scan runs")
    `CFSR_ASSERT_NOW(a_write_no_overlap, init_we, !scan_we, "scanner writes during clear pass")
    `CFSR_ASSERT_NEXT(a_read_result, result_load, result_valid_reg, "read result lost")
    `CFSR_ASSERT_NOW(a_point_idle, pt_we, state_reg == ST_IDLE, "point write outside idle")

endmodule

### verif/frame_shape_checker.sv
// ----------------------------------------------------------------------------
// frame_shape_checker
// Watches the command, result and configuration channels of the character
// frame rasterizer, keeps its own copy of the frame store and the canvas size,
// and compares each pixel read transfer with the value it predicts.
// ----------------------------------------------------------------------------
module frame_shape_checker
    import cfsr_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  logic [2:0]        command,
    input  logic signed [7:0] row_a,
    input  logic signed [7:0] col_a,
    input  logic signed [7:0] row_b,
    input  logic signed [7:0] col_b,
    input  logic [6:0]        radius,
    input  logic [7:0]        glyph,

    input  logic              result_valid,
    input  logic              result_stall,
    input  logic [7:0]        pixel_value,

    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,

    output int                mismatch_count,
    output int                pixels_pending
);

    // Shadow frame store and canvas size
    logic [CHAR_W-1:0] frame_copy [MAX_WIDTH*MAX_HEIGHT];
    logic [DIM_W-1:0]  canvas_width;
    logic [DIM_W-1:0]  canvas_height;

    // Pixels that outstanding reads should return, oldest first
    logic [CHAR_W-1:0] expected_pixels [$];
    logic [CHAR_W-1:0] oldest_pixel;

    task automatic report_mismatch(input string msg);
        begin
            $display("%0t: pixel check: %s", $time, msg);
            mismatch_count++;
        end
    endtask

    // Apply one accepted command to the shadow store
    task automatic rasterize_command(
        input logic [2:0]        code,
        input logic signed [7:0] row0_f,
        input logic signed [7:0] col0_f,
        input logic signed [7:0] row1_f,
        input logic signed [7:0] col1_f,
        input logic [6:0]        rad_f,
        input logic [7:0]        ink
    );
        int  row0, col0, row1, col1, rad;
        int  cols, rows, dr, dc, dist2;
        bit  hit;
        begin
            row0 = row0_f;
            col0 = col0_f;
            row1 = row1_f;
            col1 = col1_f;
            rad  = rad_f;
            // active sizes above the store saturate
            cols = (canvas_width  > MAX_WIDTH)  ? MAX_WIDTH  : canvas_width;
            rows = (canvas_height > MAX_HEIGHT) ? MAX_HEIGHT : canvas_height;

            case (code)
                OP_RING, OP_DISK: begin
                    for (int i = 0; i < rows; i++) begin
                        for (int j = 0; j < cols; j++) begin
                            dr    = i - row0;
                            dc    = j - col0;
                            dist2 = dr * dr + dc * dc;
                            if (code == OP_RING)
                                hit = (dist2 >= rad * (rad - 1)) && (dist2 <= rad * (rad + 1));
                            else
                                hit = (dist2 <= rad * rad);
                            frame_copy[i*MAX_WIDTH + j] = hit ? ink : SPACE_CHAR;
                        end
                    end
                end
                OP_RECT, OP_BOX: begin
                    // clipped box; empty when corners are swapped
                    for (int i = 0; i < rows; i++) begin
                        for (int j = 0; j < cols; j++) begin
                            if (i >= row0 && i <= row1 && j >= col0 && j <= col1) begin
                                if (code == OP_BOX || i == row0 || i == row1 ||
                                    j == col0 || j == col1)
                                    frame_copy[i*MAX_WIDTH + j] = ink;
                            end
                        end
                    end
                end
                OP_POINT: begin
                    if (row0 >= 0 && row0 < rows && col0 >= 0 && col0 < cols)
                        frame_copy[row0*MAX_WIDTH + col0] = ink;
                end
                OP_CLEAR: begin
                    for (int i = 0; i < rows; i++)
                        for (int j = 0; j < cols; j++)
                            frame_copy[i*MAX_WIDTH + j] = SPACE_CHAR;
                end
                OP_READ: begin
                    // off canvas reads give a space
                    if (row0 >= 0 && row0 < rows && col0 >= 0 && col0 < cols)
                        expected_pixels.push_back(frame_copy[row0*MAX_WIDTH + col0]);
                    else
                        expected_pixels.push_back(SPACE_CHAR);
                end
                default: ; // unused code: no effect, no result
            endcase
        end
    endtask

    // Channel monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < MAX_WIDTH*MAX_HEIGHT; k++)
                frame_copy[k] = SPACE_CHAR;
            canvas_width  = 7'd64;
            canvas_height = 7'd64;
            expected_pixels.delete();
            mismatch_count = 0;
            pixels_pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WIDTH)
                    canvas_width = cfg_data;
                else
                    canvas_height = cfg_data;
            end

            if (cmd_valid && !cmd_stall)
                rasterize_command(command, row_a, col_a, row_b, col_b, radius, glyph);

            if (result_valid && !result_stall) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("transfer of %0d with no read outstanding",
                                              pixel_value));
                end
                else begin
                    oldest_pixel = expected_pixels.pop_front();
                    if (pixel_value !== oldest_pixel)
                        report_mismatch($sformatf("read returned %0d, expected %0d",
                                                  pixel_value, oldest_pixel));
                end
            end

            pixels_pending <= expected_pixels.size();
        end
    end

endmodule

### verif/tb_char_frame_shape_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_char_frame_shape_rasterizer
// Drives drawing commands and canvas size writes into the rasterizer, with
// random idle bursts on both channels and one long hold on the result side;
// the checker beside the block predicts every pixel read.
// ----------------------------------------------------------------------------
module tb_char_frame_shape_rasterizer
    import cfsr_pkg::*;
();

    localparam int         MAX_WIDTH        = 64;
    localparam int         MAX_HEIGHT       = 64;
    localparam int         IDLE_LIMIT       = 50000;
    localparam int         SETTLE_CYCLES    = 4200;
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam logic [2:0] OP_UNUSED        = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    logic [2:0]        command;
    logic signed [7:0] row_a;
    logic signed [7:0] col_a;
    logic signed [7:0] row_b;
    logic signed [7:0] col_b;
    logic [6:0]        radius;
    logic [7:0]        glyph;
    logic              result_valid;
    logic              result_stall;
    logic [7:0]        pixel_value;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [6:0]        cfg_data;

    int mismatch_count;
    int pixels_pending;
    int idle_cycles = 0;
    int sender_calm;
    int receiver_calm;
    bit sender_idles;
    bit quiet_tail;
    bit hold_results;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    char_frame_shape_rasterizer #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .row_a        (row_a),
        .col_a        (col_a),
        .row_b        (row_b),
        .col_b        (col_b),
        .radius       (radius),
        .glyph        (glyph),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_value  (pixel_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    frame_shape_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .command        (command),
        .row_a          (row_a),
        .col_a          (col_a),
        .row_b          (row_b),
        .col_b          (col_b),
        .radius         (radius),
        .glyph          (glyph),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .pixel_value    (pixel_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pixels_pending (pixels_pending)
    );

    // Watchdog: cycles without any transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((cmd_valid && !cmd_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Both size registers; valid drops once, after the second transfer
    task automatic write_register(input logic idx, input int value);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value[6:0];
            do @(posedge clk); while (!cfg_ready);
        end
    endtask

    task automatic set_canvas(input int cols, input int rows);
        begin
            write_register(CFG_WIDTH, cols);
            write_register(CFG_HEIGHT, rows);
            cfg_valid <= 1'b0;
        end
    endtask

    // One command transfer, with an optional idle burst in front
    task automatic issue_command(
        input logic [2:0] code,
        input int         ra,
        input int         ca,
        input int         rb,
        input int         cb,
        input int         rad,
        input int         ink
    );
        int gap;
        begin
            gap = 0;
            if (sender_idles && !quiet_tail)
            begin
                if (sender_calm > 0)
                    sender_calm--;
                else if ($urandom_range(0, 9) == 0)
                    sender_calm = $urandom_range(5, 20);
                else if ($urandom_range(0, 2) == 0)
                    gap = $urandom_range(1, 10);
            end
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            cmd_valid <= 1'b1;
            command   <= code;
            row_a     <= ra[7:0];
            col_a     <= ca[7:0];
            row_b     <= rb[7:0];
            col_b     <= cb[7:0];
            radius    <= rad[6:0];
            glyph     <= ink[7:0];
            do @(posedge clk); while (cmd_stall);
        end
    endtask

    // Mostly near the active canvas, sometimes anywhere in the signed range
    function automatic int pick_coord(input int span);
        int lim;
        begin
            lim = (span > 64) ? 64 : span;
            case ($urandom_range(0, 9))
                7, 8:    return int'($urandom_range(0, 255)) - 128;
                9:       return ($urandom_range(0, 1) != 0) ? 127 : -128;
                default: return int'($urandom_range(0, lim + 1)) - 1;
            endcase
        end
    endfunction

    task automatic issue_random_command(input int cols, input int rows);
        int         pick, ra, ca, rb, cb, rad;
        logic [2:0] code;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 36)      code = OP_READ;
            else if (pick < 50) code = OP_POINT;
            else if (pick < 62) code = OP_RECT;
            else if (pick < 74) code = OP_BOX;
            else if (pick < 82) code = OP_RING;
            else if (pick < 90) code = OP_DISK;
            else if (pick < 95) code = OP_CLEAR;
            else                code = OP_UNUSED;
            ra = pick_coord(rows);
            ca = pick_coord(cols);
            // mostly well-formed boxes, some with arbitrary corners
            if ($urandom_range(0, 3) == 0)
            begin
                rb = pick_coord(rows);
                cb = pick_coord(cols);
            end
            else
            begin
                rb = ra + int'($urandom_range(0, 8));
                cb = ca + int'($urandom_range(0, 8));
            end
            rad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
            issue_command(code, ra, ca, rb, cb, rad, $urandom_range(0, 255));
        end
    endtask

    // Close a phase: a read marks the end, then let any scan run out
    task automatic settle();
        begin
            issue_command(OP_READ, 0, 0, 0, 0, 0, 0);
            cmd_valid <= 1'b0;
            do @(posedge clk); while (pixels_pending != 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic run_random_phase(input int cols, input int rows, input int count);
        begin
            set_canvas(cols, rows);
            repeat (count) issue_random_command(cols, rows);
            settle();
        end
    endtask

    // Result side: random stall bursts, calm stretches, one long hold on request
    initial
    begin
        result_stall  <= 1'b0;
        receiver_calm = 0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_results = 1'b0;
            end
            else if (!quiet_tail)
            begin
                if (receiver_calm > 0)
                    receiver_calm--;
                else if ($urandom_range(0, 29) == 0)
                    receiver_calm = $urandom_range(10, 40);
                else if ($urandom_range(0, 4) == 0)
                begin
                    result_stall <= 1'b1;
                    repeat ($urandom_range(1, 10)) @(posedge clk);
                    result_stall <= 1'b0;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        command   <= OP_READ;
        row_a     <= '0;
        col_a     <= '0;
        row_b     <= '0;
        col_b     <= '0;
        radius    <= '0;
        glyph     <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= '0;
        sender_idles = 1'b1;
        quiet_tail   = 1'b0;
        hold_results = 1'b0;
        sender_calm  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // full canvas; sizes above the store saturate
        set_canvas(127, 127);
        issue_command(OP_READ, 0, 0, 0, 0, 0, 0);
        issue_command(OP_POINT, 0, 0, 0, 0, 0, 255);
        issue_command(OP_POINT, 63, 63, 0, 0, 0, 0);
        issue_command(OP_POINT, 64, 0, 0, 0, 0, 8'h41);
        issue_command(OP_POINT, -1, 5, 0, 0, 0, 8'h42);
        issue_command(OP_READ, 0, 0, 0, 0, 0, 0);
        issue_command(OP_READ, 63, 63, 0, 0, 0, 0);
        issue_command(OP_READ, -128, 127, 0, 0, 0, 0);
        issue_command(OP_BOX, -128, -128, 127, 127, 0, 8'h55);
        issue_command(OP_RECT, 2, 3, 10, 20, 127, 8'h23);
        issue_command(OP_RECT, 10, 0, 5, 5, 0, 8'h78);
        issue_command(OP_BOX, 0, 10, 5, 5, 0, 8'h79);
        issue_command(OP_READ, 2, 3, 0, 0, 0, 0);
        issue_command(OP_READ, 5, 10, 0, 0, 0, 0);
        issue_command(OP_RING, 31, 31, 0, 0, 10, 8'h2a);
        issue_command(OP_READ, 31, 41, 0, 0, 0, 0);
        issue_command(OP_DISK, -128, 127, 0, 0, 127, 8'h6f);
        issue_command(OP_RING, 5, 5, 0, 0, 0, 8'h2e);
        issue_command(OP_READ, 5, 5, 0, 0, 0, 0);
        issue_command(OP_DISK, 0, 0, -128, -128, 127, 8'h40);
        issue_command(OP_UNUSED, 127, 127, 127, 127, 127, 255);
        issue_command(OP_READ, 63, 0, 0, 0, 0, 0);
        issue_command(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        settle();

        // empty canvas in either direction
        set_canvas(0, 5);
        issue_command(OP_BOX, 0, 0, 10, 10, 0, 8'h21);
        issue_command(OP_POINT, 0, 0, 0, 0, 0, 8'h22);
        settle();
        set_canvas(5, 0);
        issue_command(OP_DISK, 2, 2, 0, 0, 127, 8'h24);
        settle();

        // single cell canvas
        set_canvas(1, 1);
        issue_command(OP_POINT, 0, 0, 0, 0, 0, 8'h5a);
        issue_command(OP_READ, 0, 1, 0, 0, 0, 0);
        settle();

        run_random_phase($urandom_range(2, 16), $urandom_range(2, 16), 15);
        run_random_phase(3, 64, 14);

        // reads pile up behind a long result hold until the block stalls its input
        set_canvas(12, 12);
        sender_idles = 1'b0;
        hold_results = 1'b1;
        repeat (12) issue_command(OP_READ, pick_coord(12), pick_coord(12), 0, 0, 0, 0);
        sender_idles = 1'b1;
        repeat (7) issue_random_command(12, 12);
        settle();

        run_random_phase(64, 64, 6);
        run_random_phase(127, 9, 14);
        run_random_phase($urandom_range(1, 64), $urandom_range(1, 6), 14);

        // last part with no idling on either side
        quiet_tail = 1'b1;
        run_random_phase(20, 16, 22);

        if (mismatch_count == 0 && pixels_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/cfsr_pkg.sv
hw/rtl/cfsr_frame_mem.sv
hw/rtl/cfsr_scan.sv
hw/rtl/char_frame_shape_rasterizer.sv
verif/frame_shape_checker.sv
verif/tb_char_frame_shape_rasterizer.sv
